// ----- hw/rtl/bfiq_pkg.sv -----
// Shared types and constants for the Bloom filter insert/query unit.
// Holds the hash salts, mixing constants, register indexes and the control state type.
// No dependencies.
package bfiq_pkg;

    localparam int KEY_W     = 64;
    localparam int NUM_SALTS = 7;
    localparam int DIV_W     = 11;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic REG_WORD_COUNT = 1'b0;
    localparam logic REG_NUM_HASHES = 1'b1;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_READ,
        S_UPDATE,
        S_RESULT
    } t_state;

    function automatic logic [63:0] probe_salt(input logic [2:0] probe);
        logic [63:0] salt;
        case (probe)
            3'd0:    salt = 64'h9e3779b97f4a7c15;
            3'd1:    salt = 64'hbf58476d1ce4e5b9;
            3'd2:    salt = 64'h94d049bb133111eb;
            3'd3:    salt = 64'hff51afd7ed558ccd;
            3'd4:    salt = 64'hc4ceb9fe1a85ec53;
            3'd5:    salt = 64'h85ebca77c2b2ae63;
            3'd6:    salt = 64'hcc9e2d51a4093822;
            default: salt = '0;
        endcase
        return salt;
    endfunction

endpackage

// ----- hw/rtl/bfiq_hash.sv -----
// Salted 64-bit mixing hash for one probe, computed iteratively.
// Uses one shared 32x32 multiplier; depends on bfiq_pkg.
module bfiq_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0]            i_probe,
    input  logic [bfiq_pkg::KEY_W-1:0] i_key,
    output logic                  o_done,
    output logic [bfiq_pkg::KEY_W-1:0] o_hash
);
    import bfiq_pkg::*;

    logic [63:0] r_z, n_z;
    logic [63:0] r_acc, n_acc;
    logic [2:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] seed;
    logic [63:0] mul_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] sum_hi;
    logic [63:0] m;

    assign seed   = i_key ^ probe_salt(i_probe);
    assign mul_c  = (r_step < 3'd3) ? MIX_C1 : MIX_C2;
    assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
    assign sum_hi = r_acc[63:32] + prod[31:0];
    assign m      = {sum_hi, r_acc[31:0]};

    always_comb begin
        mul_a  = r_z[31:0];
        mul_b  = mul_c[31:0];
        n_z    = r_z;
        n_acc  = r_acc;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_z    = seed ^ (seed >> 30);
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_step = r_step + 3'd1;
            case (r_step) inside
                3'd0, 3'd3: begin
                    n_acc = prod;
                end
                3'd1, 3'd4: begin
                    mul_b = mul_c[63:32];
                    n_acc = m;
                end
                3'd2: begin
                    mul_a = r_z[63:32];
                    n_z   = m ^ (m >> 27);
                end
                3'd5: begin
                    mul_a  = r_z[63:32];
                    n_z    = m ^ (m >> 31);
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z   <= n_z;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_hash = r_z;

endmodule

// ----- hw/rtl/bfiq_mod.sv -----
// Iterative remainder unit: 64-bit dividend modulo an 11-bit divisor, eight bits a cycle.
// Depends on bfiq_pkg.
module bfiq_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_dividend,
    input  logic [bfiq_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [bfiq_pkg::DIV_W-1:0] o_rem
);
    import bfiq_pkg::*;

    logic [63:0]      r_num, n_num;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_div;
    logic [2:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        logic [DIV_W:0] t;
        t      = '0;
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            for (int i = 0; i < 8; i++) begin
                t     = {n_rem, n_num[63]};
                n_num = n_num << 1;
                if (t >= {1'b0, r_div}) begin
                    t = t - {1'b0, r_div};
                end
                n_rem = t[DIV_W-1:0];
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- hw/rtl/bfiq_store.sv -----
// Bit store of 64-bit words: one write port and one read port with registered read data.
// No package dependency.
module bfiq_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data
);
    logic [63:0] mem [DEPTH];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/bloom_filter_insert_query_unit.sv -----
// Top level of the Bloom filter insert/query unit: control, configuration port and streams.
// Instantiates bfiq_hash, bfiq_mod and bfiq_store; depends on bfiq_pkg.
//
// Each word carries a 64-bit key in tdata and the mode in tuser (0 adds, 1 queries).
// For every probe the unit hashes the salted key with the shared 32x32 multiplier,
// reduces the upper hash bits modulo the word count in the remainder unit (eight
// bits a cycle), then reads one store word and, for an add, sets the probe's bit in it.
// An add with k probes runs all k of them; a query stops at the first clear bit.
// One item is in work at a time; the result register lets a query result wait
// while the next word is taken. After reset a clearing pass writes zero to every
// store word, during which no word is accepted; register writes are taken at any time.
module bloom_filter_insert_query_unit #(
    parameter int MAX_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream: tdata = key[63:0]; tuser = mode.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    // Output stream: tdata = maybe_present[0], zeros above.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfiq_pkg::*;

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [16:0] MaxWords = 17'(MAX_WORDS);
    localparam logic [AW-1:0] LastAddr = AW'(MAX_WORDS - 1);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [2:0]       r_probe, n_probe;
    logic [63:0]      r_key, n_key;
    logic             r_mode, n_mode;
    logic             r_result, n_result;
    logic             r_out_valid, n_out_valid;
    logic             r_out_bit, n_out_bit;
    logic [10:0]      r_word_count;
    logic [2:0]       r_num_hashes;

    logic [10:0]      words;
    logic [2:0]       probes;
    logic             last_probe;
    logic             hash_start, hash_done;
    logic [63:0]      hash_value;
    logic             mod_start, mod_done;
    logic [10:0]      mod_rem;
    logic             rd_en, wr_en;
    logic [AW-1:0]    word_addr, wr_addr;
    logic [63:0]      rd_data, wr_data, bit_mask;
    logic             cfg_write;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= 11'd1024;
            r_num_hashes <= 3'd7;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WORD_COUNT) begin
                r_word_count <= pwdata[10:0];
            end else begin
                r_num_hashes <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_NUM_HASHES) begin
            prdata = {29'd0, r_num_hashes};
        end else begin
            prdata = {21'd0, r_word_count};
        end
    end

    always_comb begin
        if (r_word_count == '0) begin
            words = 11'd1;
        end else if ({6'd0, r_word_count} > MaxWords) begin
            words = MaxWords[10:0];
        end else begin
            words = r_word_count;
        end
    end

    assign probes     = (r_num_hashes == '0) ? 3'd1 : r_num_hashes;
    assign last_probe = (r_probe == probes - 3'd1);
    assign word_addr  = AW'(mod_rem);
    assign bit_mask   = 64'd1 << hash_value[5:0];

    bfiq_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_probe (n_probe),
        .i_key   (n_key),
        .o_done  (hash_done),
        .o_hash  (hash_value)
    );

    bfiq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend ({6'd0, hash_value[63:6]}),
        .i_divisor  (words),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    bfiq_store #(
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (word_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_probe       = r_probe;
        n_key         = r_key;
        n_mode        = r_mode;
        n_result      = r_result;
        n_out_valid   = r_out_valid;
        n_out_bit     = r_out_bit;
        hash_start    = 1'b0;
        mod_start     = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = word_addr;
        wr_data       = rd_data | bit_mask;
        s_axis_tready = 1'b0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                if (r_clr == LastAddr) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_key      = s_axis_tdata;
                    n_mode     = s_axis_tuser;
                    n_probe    = '0;
                    hash_start = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (r_mode == MODE_QUERY) begin
                    if ((rd_data & bit_mask) == '0) begin
                        n_result = 1'b0;
                        n_state  = S_RESULT;
                    end else if (last_probe) begin
                        n_result = 1'b1;
                        n_state  = S_RESULT;
                    end else begin
                        n_probe    = r_probe + 3'd1;
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end
                end else begin
                    wr_en = 1'b1;
                    if (last_probe) begin
                        n_state = S_IDLE;
                    end else begin
                        n_probe    = r_probe + 3'd1;
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_probe     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_probe     <= n_probe;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_mode    <= n_mode;
        r_result  <= n_result;
        r_out_bit <= n_out_bit;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_bit};

    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> r_state == S_HASH)
        else $error("hash finished outside the hash step");

    a_mod_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> mod_rem < words)
        else $error("word index not below the word count");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH) |-> r_probe < probes)
        else $error("probe index past the probe count");

    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_mode == MODE_QUERY) |-> !wr_en)
        else $error("query wrote the store");

endmodule
